>>> hdl/l2p_pkg.sv
package l2p_pkg;

    localparam int WORD_LIMIT_DEF = 64;

    localparam int ID_W     = 7;
    localparam int CAP_W    = 16;
    localparam int LETTER_W = 5;
    localparam int MAX_RES  = 3;
    localparam int CNT_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    // Marker phonemes
    localparam logic [ID_W-1:0] PH_NONE  = 7'd0;
    localparam logic [ID_W-1:0] PH_BEGIN = 7'd1;
    localparam logic [ID_W-1:0] PH_END   = 7'd2;
    localparam logic [ID_W-1:0] PH_PAUSE = 7'd3;

    // Letter index of 'e' (silent trailing e)
    localparam logic [LETTER_W-1:0] LTR_E = 5'd4;

    // Character codes
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;

    typedef logic [ID_W-1:0] id_t;

    // Results of one item, in delivery order
    typedef struct packed {
        logic [CNT_W-1:0]             n;
        logic [MAX_RES-1:0][ID_W-1:0] ids;
    } l2p_res_t;

    // Fixed-width per-text state
    typedef struct packed {
        logic [LETTER_W-1:0] pend_letter;
        logic                pend_valid;
        logic [CAP_W-1:0]    committed;
        logic [CAP_W-1:0]    emitted;
        logic                started;
        logic                stopped;
    } l2p_ctl_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic [ID_W-1:0]     id;
    } pair_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
    } pair_hit_t;

    localparam id_t LETTER_IDS [26] = '{
        7'd6,  7'd10, 7'd23, 7'd12, 7'd14, 7'd17, 7'd18, 7'd19, 7'd20,
        7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd28, 7'd30, 7'd23, 7'd31,
        7'd32, 7'd34, 7'd36, 7'd38, 7'd39, 7'd23, 7'd40, 7'd41
    };

    // Digraphs as letter indexes: th sh ch ng ph wh ck ee oo ou ow ai ay ea oi oy
    localparam pair_t PAIR_TAB [16] = '{
        '{5'd19, 5'd7,  7'd35}, '{5'd18, 5'd7,  7'd33},
        '{5'd2,  5'd7,  7'd11}, '{5'd13, 5'd6,  7'd27},
        '{5'd15, 5'd7,  7'd17}, '{5'd22, 5'd7,  7'd39},
        '{5'd2,  5'd10, 7'd23}, '{5'd4,  5'd4,  7'd21},
        '{5'd14, 5'd14, 7'd37}, '{5'd14, 5'd20, 7'd8},
        '{5'd14, 5'd22, 7'd28}, '{5'd0,  5'd8,  7'd16},
        '{5'd0,  5'd24, 7'd16}, '{5'd4,  5'd0,  7'd21},
        '{5'd14, 5'd8,  7'd29}, '{5'd14, 5'd24, 7'd29}
    };

    function automatic id_t letter_id(input logic [LETTER_W-1:0] li);
        id_t r;
        r = PH_NONE;
        if (li < 5'd26)
        begin
            r = LETTER_IDS[li];
        end
        return r;
    endfunction

    function automatic pair_hit_t pair_lookup(input logic [LETTER_W-1:0] a,
                                              input logic [LETTER_W-1:0] b);
        pair_hit_t r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (PAIR_TAB[i].first == a && PAIR_TAB[i].second == b)
            begin
                r.hit = 1'b1;
                r.id  = PAIR_TAB[i].id;
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/l2p_core.sv
// One item step: current state plus one character gives the results and next state.
module l2p_core
    import l2p_pkg::*;
#(
    parameter int WORD_LIMIT = WORD_LIMIT_DEF,
    parameter int WL_W       = $clog2(WORD_LIMIT)
)
(
    input  logic [7:0]       char_code,
    input  logic             has_char,
    input  logic             end_of_text,
    input  logic [CAP_W-1:0] capacity,
    input  l2p_ctl_t         ctl,
    input  logic [WL_W-1:0]  word_len,
    output l2p_res_t         res,
    output l2p_ctl_t         ctl_next,
    output logic [WL_W-1:0]  word_len_next
);

    localparam logic [WL_W-1:0] WL_MAX = WL_W'(WORD_LIMIT - 1);
    localparam logic [WL_W-1:0] WL_TWO = WL_W'(2);

    logic [CAP_W-1:0]    e0;
    logic [CAP_W-1:0]    c0;
    logic [3:0]          ok;
    logic [7:0]          lc;
    logic [LETTER_W-1:0] li;
    pair_hit_t           ph;
    logic                stop1;
    logic [WL_W-1:0]     wl1;
    logic                pv1;
    logic [LETTER_W-1:0] pl1;
    logic                commit;
    logic [3:0]          cand_v;
    id_t                 cand_id [4];
    id_t                 ids [4];
    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    nc;
    logic [CNT_W-1:0]    nc_char;

    always_comb
    begin
        e0 = ctl.started ? ctl.emitted : 16'd1;
        c0 = ctl.started ? ctl.committed : 16'd1;
        for (int k = 0; k < 3; k++)
        begin
            ok[k] = ({1'b0, e0} + 17'(k)) < {1'b0, capacity};
        end
        ok[3] = 1'b0;

        lc = (char_code >= CH_UP_A && char_code <= CH_UP_Z) ? char_code + CASE_DELTA
                                                           : char_code;
        li = LETTER_W'(lc - CH_LO_A);
        ph = pair_lookup(ctl.pend_letter, li);

        stop1   = ctl.stopped;
        wl1     = word_len;
        pv1     = ctl.pend_valid;
        pl1     = ctl.pend_letter;
        commit  = 1'b0;
        cand_v  = '0;
        for (int j = 0; j < 4; j++)
        begin
            cand_id[j] = PH_NONE;
        end

        if (has_char && !ctl.stopped && ({1'b0, c0} + 17'd1) >= {1'b0, capacity})
        begin
            stop1 = 1'b1;
        end

        // character path
        if (has_char && !stop1)
        begin
            if (lc >= CH_LO_A && lc <= CH_LO_Z)
            begin
                if (word_len < WL_MAX)
                begin
                    wl1 = word_len + WL_W'(1);
                    if (ctl.pend_valid)
                    begin
                        cand_v[0] = 1'b1;
                        if (ph.hit)
                        begin
                            cand_id[0] = ph.id;
                            pv1        = 1'b0;
                        end
                        else
                        begin
                            cand_id[0] = letter_id(ctl.pend_letter);
                            pl1        = li;
                        end
                    end
                    else
                    begin
                        pl1 = li;
                        pv1 = 1'b1;
                    end
                end
            end
            else
            begin
                if (word_len != '0)
                begin
                    cand_v[0]  = ctl.pend_valid &&
                                 !(ctl.pend_letter == LTR_E && word_len > WL_TWO);
                    cand_id[0] = letter_id(ctl.pend_letter);
                    commit     = 1'b1;
                end
                wl1 = '0;
                pv1 = 1'b0;
                pl1 = '0;
                if (lc == CH_SPACE || lc == CH_COMMA || lc == CH_PERIOD ||
                    lc == CH_BANG || lc == CH_QUEST)
                begin
                    cand_v[1]  = 1'b1;
                    cand_id[1] = PH_PAUSE;
                    commit     = 1'b1;
                end
            end
        end

        // end of text: flush the word, then the end marker
        if (end_of_text)
        begin
            cand_v[2]  = (wl1 != '0) && pv1 && !(pl1 == LTR_E && wl1 > WL_TWO);
            cand_id[2] = letter_id(pl1);
            cand_v[3]  = 1'b1;
            cand_id[3] = PH_END;
        end

        // pack results; capacity cuts off every later capped output
        for (int j = 0; j < 4; j++)
        begin
            ids[j] = PH_NONE;
        end
        n  = '0;
        nc = '0;
        nc_char = '0;
        if (!ctl.started)
        begin
            ids[0] = PH_BEGIN;
            n      = 2'd1;
        end
        for (int j = 0; j < 4; j++)
        begin
            if (cand_v[j] && ok[nc])
            begin
                ids[n] = cand_id[j];
                n      = n + 2'd1;
                nc     = nc + 2'd1;
            end
            if (j == 1)
            begin
                nc_char = nc;
            end
        end

        res.n      = n;
        res.ids[0] = ids[0];
        res.ids[1] = ids[1];
        res.ids[2] = ids[2];

        ctl_next      = ctl;
        word_len_next = word_len;
        if (!has_char && !end_of_text)
        begin
            res.n = '0;
        end
        else if (end_of_text)
        begin
            ctl_next      = '0;
            word_len_next = '0;
        end
        else
        begin
            ctl_next.started     = 1'b1;
            ctl_next.stopped     = stop1;
            ctl_next.pend_letter = pl1;
            ctl_next.pend_valid  = pv1;
            ctl_next.emitted     = e0 + CAP_W'(nc);
            ctl_next.committed   = commit ? e0 + CAP_W'(nc_char) : c0;
            word_len_next        = wl1;
        end
    end

endmodule

>>> hdl/l2p_out_buf.sv
// Result register: holds the results of one item, drains one per transfer.
module l2p_out_buf
    import l2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  l2p_res_t   load_res,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [MAX_RES-1:0][ID_W-1:0] ids_reg;
    logic [MAX_RES-1:0][ID_W-1:0] ids_next;
    logic                         fire;

    assign m_tvalid = (cnt_reg != '0);
    assign fire     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == '0) || (cnt_reg == 2'd1 && m_tready);
    assign m_tdata  = {1'b0, ids_reg[0]};
    assign m_tlast  = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        ids_next = ids_reg;
        if (load && load_res.n != '0)
        begin
            cnt_next = load_res.n;
            ids_next = load_res.ids;
        end
        else if (fire)
        begin
            cnt_next    = cnt_reg - 2'd1;
            ids_next[0] = ids_reg[1];
            ids_next[1] = ids_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg <= ids_next;
    end

endmodule

>>> hdl/letter_to_phoneme_stream.sv
// Channel   Dir  tdata               tuser       tlast
// s_*       in   [7:0] char_code     [0] has_char end_of_text
// m_*       out  [6:0] phone_idx     -            last_in_run
// cfg       in   output_capacity_we / output_capacity_wdata[15:0], no read-back
//
// An input transfer lands in an input register; the step logic turns it into
// 0..3 phoneme IDs that load the result register in one go once it is free.
// Throughput is one character per cycle while each yields at most one result
// and m_tready is high; an item with k results holds the result register for
// k output transfers. s_tready drops only when the input register is full and
// cannot move on. Reset clears all text state and sets output_capacity to 256.
module letter_to_phoneme_stream
    import l2p_pkg::*;
#(
    parameter int WORD_LIMIT = WORD_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // input character stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] char_code
    input  logic [0:0]       s_tuser,   // [0] has_char
    input  logic             s_tlast,   // end_of_text
    // phoneme stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [6:0] phone_idx, [7] zero
    output logic             m_tlast,   // last_in_run
    // output_capacity register
    input  logic             output_capacity_we,
    input  logic [CAP_W-1:0] output_capacity_wdata
);

    localparam int WL_W = $clog2(WORD_LIMIT);

    // input register
    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             has_reg;
    logic             eot_reg;
    logic             s_fire;
    logic             move;

    // text state
    l2p_ctl_t         ctl_reg;
    l2p_ctl_t         ctl_next;
    logic [WL_W-1:0]  word_len_reg;
    logic [WL_W-1:0]  word_len_next;
    logic [CAP_W-1:0] cap_reg;

    l2p_res_t         res;
    logic             buf_can_load;

    // An item with no results may leave at any time; otherwise the result
    // register must be free by the end of this cycle.
    assign move     = in_valid_reg && (res.n == '0 || buf_can_load);
    assign s_tready = !in_valid_reg || move;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            char_reg <= s_tdata;
            has_reg  <= s_tuser[0];
            eot_reg  <= s_tlast;
        end
    end

    // State advances exactly when an item hands its results on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg      <= '0;
            word_len_reg <= '0;
            cap_reg      <= CAP_RESET;
        end
        else
        begin
            if (move)
            begin
                ctl_reg      <= ctl_next;
                word_len_reg <= word_len_next;
            end
            if (output_capacity_we)
            begin
                cap_reg <= output_capacity_wdata;
            end
        end
    end

    l2p_core #(
        .WORD_LIMIT (WORD_LIMIT),
        .WL_W       (WL_W)
    ) u_core (
        .char_code     (char_reg),
        .has_char      (has_reg),
        .end_of_text   (eot_reg),
        .capacity      (cap_reg),
        .ctl           (ctl_reg),
        .word_len      (word_len_reg),
        .res           (res),
        .ctl_next      (ctl_next),
        .word_len_next (word_len_next)
    );

    l2p_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (move),
        .load_res (res),
        .can_load (buf_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/l2p_checker.sv
module l2p_checker
    import l2p_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no result shown on the first edge out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // never a zero or out-of-range id
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7] == 1'b0 && m_tdata[6:0] != PH_NONE)
        else $error("bad phoneme id");

    // end marker always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6:0] == PH_END |-> m_tlast)
        else $error("end marker not last");

endmodule

bind letter_to_phoneme_stream l2p_checker u_l2p_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> verif/letter_to_phoneme_stream_tb.sv
module letter_to_phoneme_stream_tb;
    import l2p_pkg::*;

    // One text character as it crosses the input channel
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       end_of_text;
    } text_item_t;

    // One phoneme as it should leave the output channel
    typedef struct packed {
        id_t  phone_idx;
        logic last_in_run;
    } phoneme_t;

    localparam int WORD_KEEP = WORD_LIMIT_DEF - 1;  // letters kept per word
    localparam logic [LETTER_W-1:0] IDX_E = 5'd4;   // letter index of 'e'
    localparam int SETTLE_CYCLES = 8;                // input reg + result reg, with margin

    // Single-letter phonemes, a..z
    localparam id_t SINGLE_IDS [26] = '{
        7'd6,  7'd10, 7'd23, 7'd12, 7'd14, 7'd17, 7'd18, 7'd19, 7'd20,
        7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd28, 7'd30, 7'd23, 7'd31,
        7'd32, 7'd34, 7'd36, 7'd38, 7'd39, 7'd23, 7'd40, 7'd41
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;     // [7:0] char_code
    logic [0:0]       s_tuser = '0;     // [0] has_char
    logic             s_tlast = 1'b0;   // end_of_text
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;          // [6:0] phone_idx, [7] zero
    logic             m_tlast;          // last_in_run
    logic             output_capacity_we = 1'b0;
    logic [CAP_W-1:0] output_capacity_wdata = '0;

    letter_to_phoneme_stream uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .s_tvalid              (s_tvalid),
        .s_tready              (s_tready),
        .s_tdata               (s_tdata),
        .s_tuser               (s_tuser),
        .s_tlast               (s_tlast),
        .m_tvalid              (m_tvalid),
        .m_tready              (m_tready),
        .m_tdata               (m_tdata),
        .m_tlast               (m_tlast),
        .output_capacity_we    (output_capacity_we),
        .output_capacity_wdata (output_capacity_wdata)
    );

    always #2 clk = ~clk;

    // Stimulus queue (front = item on the bus) and expected phonemes
    text_item_t text_q [$];
    phoneme_t   phoneme_q [$];
    id_t        run_ids [$];    // phonemes of the item being predicted

    int errors = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;          // long receiver hold-off, counted down below
    bit offer_taken = 1'b0;

    // Converter state mirror
    logic [CAP_W-1:0]    capacity = CAP_RESET;
    logic [LETTER_W-1:0] pend_letter = '0;
    logic                pend_valid = 1'b0;
    logic [6:0]          word_len = '0;
    logic [CAP_W-1:0]    committed = '0;
    logic [CAP_W-1:0]    emitted = '0;
    logic                started = 1'b0;
    logic                stopped = 1'b0;

    // ------------------------------------------------------------------
    // Phoneme prediction
    // ------------------------------------------------------------------

    function automatic id_t digraph_phoneme(input logic [LETTER_W-1:0] a,
                                            input logic [LETTER_W-1:0] b);
        logic [7:0] ca;
        logic [7:0] cb;
        id_t        r;
        ca = CH_LO_A + 8'(a);
        cb = CH_LO_A + 8'(b);
        case ({ca, cb})
            "th":    r = 7'd35;
            "sh":    r = 7'd33;
            "ch":    r = 7'd11;
            "ng":    r = 7'd27;
            "ph":    r = 7'd17;
            "wh":    r = 7'd39;
            "ck":    r = 7'd23;
            "ee":    r = 7'd21;
            "oo":    r = 7'd37;
            "ou":    r = 7'd8;
            "ow":    r = 7'd28;
            "ai":    r = 7'd16;
            "ay":    r = 7'd16;
            "ea":    r = 7'd21;
            "oi":    r = 7'd29;
            "oy":    r = 7'd29;
            default: r = PH_NONE;
        endcase
        return r;
    endfunction

    // Every output but the begin marker is limited by the capacity
    function automatic void emit_capped(input id_t id);
        if (emitted < capacity)
        begin
            run_ids.push_back(id);
            emitted = emitted + 1'b1;
        end
    endfunction

    // Word boundary: release the pending letter (a trailing 'e' of a word
    // longer than two letters stays silent) and commit the count
    function automatic void close_word();
        if (word_len != 0)
        begin
            if (pend_valid && !(pend_letter == IDX_E && word_len > 2))
                emit_capped(SINGLE_IDS[pend_letter]);
            committed = emitted;
        end
        word_len    = '0;
        pend_valid  = 1'b0;
        pend_letter = '0;
    endfunction

    function automatic void predict_phonemes(input text_item_t it);
        logic [7:0]          c;
        logic [LETTER_W-1:0] li;
        id_t                 pair;
        phoneme_t            ph;
        run_ids.delete();
        if (!it.has_char && !it.end_of_text)
            return;

        // First live item of a text opens it, regardless of capacity
        if (!started)
        begin
            run_ids.push_back(PH_BEGIN);
            emitted   = 16'd1;
            committed = 16'd1;
            started   = 1'b1;
        end

        if (it.has_char)
        begin
            // Stop taking characters once the committed count nears capacity
            if (!stopped && {1'b0, committed} + 17'd1 >= {1'b0, capacity})
                stopped = 1'b1;
            if (!stopped)
            begin
                c = it.char_code;
                if (c >= CH_UP_A && c <= CH_UP_Z)
                    c = c + CASE_DELTA;
                if (c >= CH_LO_A && c <= CH_LO_Z)
                begin
                    li = LETTER_W'(c - CH_LO_A);
                    // letters past the word limit are dropped, word goes on
                    if (word_len < WORD_KEEP)
                    begin
                        word_len = word_len + 1'b1;
                        if (pend_valid)
                        begin
                            pair = digraph_phoneme(pend_letter, li);
                            if (pair != PH_NONE)
                            begin
                                emit_capped(pair);
                                pend_valid = 1'b0;
                            end
                            else
                            begin
                                emit_capped(SINGLE_IDS[pend_letter]);
                                pend_letter = li;
                            end
                        end
                        else
                        begin
                            pend_letter = li;
                            pend_valid  = 1'b1;
                        end
                    end
                end
                else
                begin
                    // any non-letter ends the word; five of them pause
                    close_word();
                    if (c == CH_SPACE || c == CH_COMMA || c == CH_PERIOD ||
                        c == CH_BANG || c == CH_QUEST)
                    begin
                        emit_capped(PH_PAUSE);
                        committed = emitted;
                    end
                end
            end
        end

        if (it.end_of_text)
        begin
            close_word();
            emit_capped(PH_END);
            pend_letter = '0;
            pend_valid  = 1'b0;
            word_len    = '0;
            committed   = '0;
            emitted     = '0;
            started     = 1'b0;
            stopped     = 1'b0;
        end

        foreach (run_ids[i])
        begin
            ph.phone_idx   = run_ids[i];
            ph.last_in_run = (i == run_ids.size() - 1);
            phoneme_q.push_back(ph);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: transfer at posedge, next offer at negedge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready === 1'b1)
        begin
            predict_phonemes(text_q.pop_front());
            offer_taken = 1'b1;
        end
    end

    // Hold the offer until it is taken, then maybe idle or offer the next one
    always @(negedge clk)
    begin
        if (!s_tvalid || offer_taken)
        begin
            offer_taken = 1'b0;
            if (rst_n && text_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_q[0].char_code;
                s_tuser  <= text_q[0].has_char;
                s_tlast  <= text_q[0].end_of_text;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready pattern and phoneme check
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        phoneme_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (phoneme_q.size() == 0)
            begin
                $error("phone_idx: no transfer expected, got %0d (last_in_run %0b)",
                       m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = phoneme_q.pop_front();
                // pad bit must be zero, so compare the whole byte
                if (m_tdata !== {1'b0, want.phone_idx})
                begin
                    $error("phone_idx: expected %0d, got %0d", want.phone_idx, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last_in_run)
                begin
                    $error("last_in_run: expected %0b, got %0b", want.last_in_run, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_item(input logic [7:0] c, input logic has, input logic eot);
        text_item_t it;
        it.char_code   = c;
        it.has_char    = has;
        it.end_of_text = eot;
        text_q.push_back(it);
    endtask

    string digraph_letters = "thscnpwkeoaiuyg";

    // Letters biased toward digraph members, a quarter of them upper case
    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        if ($urandom_range(1))
            c = digraph_letters[$urandom_range(digraph_letters.len() - 1)];
        else
            c = CH_LO_A + 8'($urandom_range(25));
        if ($urandom_range(3) == 0)
            c = c - CASE_DELTA;
        return c;
    endfunction

    // Words with random content between separators, plus some noise:
    // stray non-letters, ends of text with and without a character, and
    // empty items (those do not count toward the total)
    task automatic gen_text(input int count);
        int         made;
        int         len;
        int         r;
        logic [7:0] c;
        made = 0;
        while (made < count)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                push_item(rand_letter(), 1'b1, 1'b0);
            if ($urandom_range(99) < 15)
            begin
                push_item("e", 1'b1, 1'b0);
                len++;
            end
            made += len;
            r = $urandom_range(99);
            if (r < 55)
            begin
                case ($urandom_range(4))
                    0: c = CH_SPACE;
                    1: c = CH_COMMA;
                    2: c = CH_PERIOD;
                    3: c = CH_BANG;
                    default: c = CH_QUEST;
                endcase
                push_item(c, 1'b1, 1'b0);
                made++;
            end
            else if (r < 72)
            begin
                do
                    c = 8'($urandom_range(255));
                while ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z));
                push_item(c, 1'b1, 1'b0);
                made++;
            end
            else if (r < 84)
            begin
                push_item(8'($urandom_range(255)), 1'b1, 1'b1);
                made++;
            end
            else if (r < 90)
            begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b1);
                made++;
            end
            else if (r >= 95)
            begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            // otherwise the next word runs straight on
        end
    endtask

    // Quiet point: everything sent, everything received, and long enough
    // for an item with no result to clear the pipeline
    task automatic wait_idle();
        while (text_q.size() != 0 || phoneme_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge clk);
        output_capacity_we    <= 1'b1;
        output_capacity_wdata <= v;
        capacity = v;
        @(negedge clk);
        output_capacity_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int sink_pct);
        send_idle_pct  = send_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text at reset capacity, no idling
        set_idling(0, 0);
        push_item(8'hFF, 1'b0, 1'b0);               // empty item, nothing out
        push_item("T", 1'b1, 1'b0);                 // opens text, upper case
        push_item("h", 1'b1, 1'b0);                 // th digraph
        push_item("e", 1'b1, 1'b0);
        push_item(CH_SPACE, 1'b1, 1'b0);            // silent trailing e, pause
        push_item("h", 1'b1, 1'b0);
        push_item("E", 1'b1, 1'b0);
        push_item(CH_BANG, 1'b1, 1'b0);             // two-letter word keeps its e
        push_item("S", 1'b1, 1'b0);
        push_item("h", 1'b1, 1'b0);
        push_item("e", 1'b1, 1'b0);
        push_item("e", 1'b1, 1'b0);
        push_item("p", 1'b1, 1'b0);
        push_item(CH_QUEST, 1'b1, 1'b0);
        push_item("c", 1'b1, 1'b0);
        push_item("k", 1'b1, 1'b0);
        push_item(CH_COMMA, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);               // NUL: no word, no pause
        push_item(CH_UP_Z, 1'b1, 1'b0);
        push_item(CH_UP_A - 8'd1, 1'b1, 1'b0);      // '@' just below the letters
        push_item(CH_LO_A, 1'b1, 1'b0);
        push_item(CH_LO_A - 8'd1, 1'b1, 1'b0);      // '`'
        push_item(CH_LO_Z + 8'd1, 1'b1, 1'b0);      // '{'
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(CH_PERIOD, 1'b1, 1'b0);
        push_item("x", 1'b1, 1'b1);                 // last letter flushed by end of text
        push_item(8'h55, 1'b0, 1'b1);               // empty text: begin and end only
        wait_idle();

        // Widest capacity, slow sender, one word past the word limit
        set_capacity(16'hFFFF);
        set_idling(78, 0);
        gen_text(90);
        for (int i = 0; i < WORD_LIMIT_DEF + 4; i++)
            push_item(rand_letter(), 1'b1, 1'b0);
        push_item(CH_SPACE, 1'b1, 1'b1);
        wait_idle();

        // Tight capacity hits truncation and input stop, slow receiver
        set_capacity(16'd5);
        set_idling(0, 78);
        gen_text(50);
        wait_idle();

        // Zero capacity: begin marker only
        set_capacity(16'd0);
        set_idling(8, 8);
        gen_text(15);
        wait_idle();

        // Capacity of one
        set_capacity(16'd1);
        set_idling(0, 0);
        gen_text(15);
        wait_idle();

        // Receiver holds off while the sender keeps offering: block backs up
        set_capacity(16'd30);
        set_idling(0, 0);
        hold_left = 300;
        gen_text(60);
        wait_idle();

        set_capacity(CAP_RESET);
        set_idling(8, 8);
        gen_text(40);
        wait_idle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
